// ===== rtl/core/plpad_pkg.sv =====
// ----------------------------------------------------------------------------
// plpad_pkg
// Types and constants shared by the polyline arc distance block.
// ----------------------------------------------------------------------------
package plpad_pkg;

   localparam int COORD_W    = 32;
   localparam int IDX_W      = 10;
   localparam int MAG_W      = 33;
   localparam int PROD_W     = 66;
   localparam int ACC_W      = 68;
   localparam int RAD_W      = 70;
   localparam int ROOT_W     = 35;
   localparam int SREM_W     = 38;
   localparam int DREM_W     = 36;
   localparam int RATIO_BITS = 28;
   localparam int POINT_W    = 3 * COORD_W;
   localparam int STEP_W     = 6;

   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(RATIO_BITS - 1);
   localparam logic [1:0]        AXIS_LAST = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LAST,
      ST_SEG_A,
      ST_SEG_B,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_CMP,
      ST_DIV,
      ST_IN_MUL,
      ST_IN_ADD,
      ST_PUB
   } state_type;

   typedef enum logic [1:0] {
      ADDR_I,
      ADDR_I1,
      ADDR_I2,
      ADDR_LAST
   } addr_sel_type;

   typedef struct packed {
      logic         load_we;
      logic         q_start;
      addr_sel_type addr_sel;
      logic         lat_a;
      logic         lat_b;
      logic         mul_sq;
      logic         acc_add;
      logic         sqrt_init;
      logic         sqrt_step;
      logic         advance;
      logic         div_init;
      logic         div_step;
      logic         mul_int;
      logic         int_apply;
      logic [1:0]   axis;
      logic         set_empty;
      logic         set_last;
      logic         set_start;
      logic         set_tail;
      logic         pub;
   } ctrl_type;

   typedef struct packed {
      logic count_zero;
      logic past_end;
      logic rem_lt_len;
      logic rem_le_zero;
      logic more_seg;
      logic out_busy;
   } stat_type;

endpackage

// ===== rtl/core/plpad_req_if.sv =====
// ----------------------------------------------------------------------------
// plpad_req_if
// Request channel: point loads and distance queries.
// ----------------------------------------------------------------------------
interface plpad_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic               first_point;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;
   logic [9:0]         start_index;
   logic signed [31:0] travel_distance;

   modport source (output valid, cmd, first_point, point_x, point_y, point_z,
                   start_index, travel_distance, input ready);
   modport sink (input valid, cmd, first_point, point_x, point_y, point_z,
                 start_index, travel_distance, output ready);
endinterface

// ===== rtl/core/plpad_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plpad_rsp_if
// Response channel: found point of a distance query.
// ----------------------------------------------------------------------------
interface plpad_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_x;
   logic signed [31:0] result_y;
   logic signed [31:0] result_z;
   logic [9:0]         orientation_index;
   logic               empty_error;

   modport source (output valid, result_x, result_y, result_z, orientation_index,
                   empty_error, input ready);
   modport sink (input valid, result_x, result_y, result_z, orientation_index,
                 empty_error, output ready);
endinterface

// ===== rtl/core/plpad_ram.sv =====
// ----------------------------------------------------------------------------
// plpad_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module plpad_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/plpad_ctrl.sv =====
// ----------------------------------------------------------------------------
// plpad_ctrl
// Sequencer for loads, the segment walk, square root, divide and interpolation.
// ----------------------------------------------------------------------------
module plpad_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_cmd,
   output logic               req_ready,
   input  plpad_pkg::stat_type stat,
   output plpad_pkg::ctrl_type ctrl
);

   plpad_pkg::state_type state_ff, state_in;
   logic [plpad_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0] axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plpad_pkg::ST_IDLE;
         step_ff  <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         axis_ff  <= axis_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         plpad_pkg::ST_IDLE: begin
            if (req_valid && req_cmd == plpad_pkg::CMD_QUERY) begin
               state_in = plpad_pkg::ST_START;
            end
         end
         plpad_pkg::ST_START: begin
            if (stat.count_zero) begin
               state_in = plpad_pkg::ST_PUB;
            end else if (stat.past_end) begin
               state_in = plpad_pkg::ST_LAST;
            end else begin
               state_in = plpad_pkg::ST_SEG_A;
            end
         end
         plpad_pkg::ST_LAST:  state_in = plpad_pkg::ST_PUB;
         plpad_pkg::ST_SEG_A: state_in = plpad_pkg::ST_SEG_B;
         plpad_pkg::ST_SEG_B: begin
            state_in = plpad_pkg::ST_SQ_MUL;
            axis_in  = '0;
         end
         plpad_pkg::ST_SQ_MUL: state_in = plpad_pkg::ST_SQ_ACC;
         plpad_pkg::ST_SQ_ACC: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == plpad_pkg::AXIS_LAST) begin
               state_in = plpad_pkg::ST_ROOT_INIT;
            end else begin
               state_in = plpad_pkg::ST_SQ_MUL;
            end
         end
         plpad_pkg::ST_ROOT_INIT: begin
            state_in = plpad_pkg::ST_ROOT;
            step_in  = '0;
         end
         plpad_pkg::ST_ROOT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == plpad_pkg::SQRT_LAST) begin
               state_in = plpad_pkg::ST_CMP;
            end
         end
         plpad_pkg::ST_CMP: begin
            if (stat.rem_lt_len) begin
               if (stat.rem_le_zero) begin
                  state_in = plpad_pkg::ST_PUB;
               end else begin
                  state_in = plpad_pkg::ST_DIV;
                  step_in  = '0;
               end
            end else if (stat.more_seg) begin
               state_in = plpad_pkg::ST_SEG_B;
            end else begin
               state_in = plpad_pkg::ST_PUB;
            end
         end
         plpad_pkg::ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == plpad_pkg::DIV_LAST) begin
               state_in = plpad_pkg::ST_IN_MUL;
               axis_in  = '0;
            end
         end
         plpad_pkg::ST_IN_MUL: state_in = plpad_pkg::ST_IN_ADD;
         plpad_pkg::ST_IN_ADD: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == plpad_pkg::AXIS_LAST) begin
               state_in = plpad_pkg::ST_PUB;
            end else begin
               state_in = plpad_pkg::ST_IN_MUL;
            end
         end
         plpad_pkg::ST_PUB: begin
            if (!stat.out_busy) begin
               state_in = plpad_pkg::ST_IDLE;
            end
         end
         default: state_in = plpad_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl      = '0;
      ctrl.axis = axis_ff;
      ctrl.addr_sel = plpad_pkg::ADDR_I;
      req_ready = 1'b0;
      unique case (state_ff)
         plpad_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.load_we = req_valid && req_cmd == plpad_pkg::CMD_LOAD;
            ctrl.q_start = req_valid && req_cmd == plpad_pkg::CMD_QUERY;
         end
         plpad_pkg::ST_START: begin
            ctrl.set_empty = stat.count_zero;
            ctrl.addr_sel  = stat.past_end ? plpad_pkg::ADDR_LAST : plpad_pkg::ADDR_I;
         end
         plpad_pkg::ST_LAST: ctrl.set_last = 1'b1;
         plpad_pkg::ST_SEG_A: begin
            ctrl.lat_a    = 1'b1;
            ctrl.addr_sel = plpad_pkg::ADDR_I1;
         end
         plpad_pkg::ST_SEG_B:     ctrl.lat_b     = 1'b1;
         plpad_pkg::ST_SQ_MUL:    ctrl.mul_sq    = 1'b1;
         plpad_pkg::ST_SQ_ACC:    ctrl.acc_add   = 1'b1;
         plpad_pkg::ST_ROOT_INIT: ctrl.sqrt_init = 1'b1;
         plpad_pkg::ST_ROOT:      ctrl.sqrt_step = 1'b1;
         plpad_pkg::ST_CMP: begin
            ctrl.addr_sel = plpad_pkg::ADDR_I2;
            if (stat.rem_lt_len) begin
               ctrl.set_start = stat.rem_le_zero;
               ctrl.div_init  = !stat.rem_le_zero;
            end else begin
               ctrl.advance  = 1'b1;
               ctrl.set_tail = !stat.more_seg;
            end
         end
         plpad_pkg::ST_DIV:    ctrl.div_step  = 1'b1;
         plpad_pkg::ST_IN_MUL: ctrl.mul_int   = 1'b1;
         plpad_pkg::ST_IN_ADD: ctrl.int_apply = 1'b1;
         plpad_pkg::ST_PUB:    ctrl.pub       = !stat.out_busy;
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/plpad_dp.sv =====
// ----------------------------------------------------------------------------
// plpad_dp
// Point store, segment length, ratio divider, interpolation and result regs.
// ----------------------------------------------------------------------------
module plpad_dp #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  plpad_pkg::ctrl_type ctrl,
   output plpad_pkg::stat_type stat,
   input  logic                req_first_point,
   input  logic signed [31:0]  req_point_x,
   input  logic signed [31:0]  req_point_y,
   input  logic signed [31:0]  req_point_z,
   input  logic [9:0]          req_start_index,
   input  logic signed [31:0]  req_travel_distance,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic signed [31:0]  rsp_result_x,
   output logic signed [31:0]  rsp_result_y,
   output logic signed [31:0]  rsp_result_z,
   output logic [9:0]          rsp_orientation_index,
   output logic                rsp_empty_error
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int IW = (CW > plpad_pkg::IDX_W) ? CW : plpad_pkg::IDX_W;
   localparam int PW = plpad_pkg::POINT_W;
   localparam int W  = plpad_pkg::COORD_W;

   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] i_ff;
   logic signed [W-1:0] remain_ff;
   logic [PW-1:0] pa_ff, pb_ff;
   logic [plpad_pkg::PROD_W-1:0] prod_ff;
   logic [plpad_pkg::ACC_W-1:0]  acc_ff;
   logic [plpad_pkg::RAD_W-1:0]  rad_ff;
   logic [plpad_pkg::SREM_W-1:0] srem_ff;
   logic [plpad_pkg::ROOT_W-1:0] root_ff;
   logic [plpad_pkg::DREM_W-1:0] drem_ff;
   logic [plpad_pkg::RATIO_BITS-1:0] ratio_ff;
   logic signed [W-1:0] res_x_ff, res_y_ff, res_z_ff;
   logic [plpad_pkg::IDX_W-1:0] res_idx_ff;
   logic res_err_ff;
   logic out_valid_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [plpad_pkg::IDX_W-1:0] out_idx_ff;
   logic out_err_ff;

   logic [PW-1:0] rd_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [IW:0]   i_ext, i_p1, i_p2, count_ext;
   logic [IW-1:0] last_idx;
   logic signed [W-1:0] va, vb;
   logic signed [W:0] diff;
   logic [plpad_pkg::MAG_W-1:0] mag, mul_b;
   logic [plpad_pkg::SREM_W-1:0] s_shift, s_trial;
   logic [plpad_pkg::DREM_W-1:0] d_shift, len_ext;
   logic [plpad_pkg::PROD_W-1:0] rounded;
   logic [plpad_pkg::MAG_W-1:0]  offset;
   logic [W:0] interp;

   // ---------------- point store ----------------
   assign count_ext = (IW+1)'(count_ff);
   assign i_ext     = {1'b0, i_ff};
   assign i_p1      = i_ext + 1'b1;
   assign i_p2      = i_ext + 2'd2;
   assign last_idx  = IW'(count_ff) - 1'b1;

   always_comb begin
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      if (ctrl.load_we) begin
         if (req_first_point) begin
            count_in = CW'(1);
            wr_en    = 1'b1;
            wr_addr  = '0;
         end else if (count_ff < CW'(MAX_POINTS)) begin
            count_in = count_ff + 1'b1;
            wr_en    = 1'b1;
         end
      end
   end

   always_comb begin
      case (ctrl.addr_sel)
         plpad_pkg::ADDR_I:    rd_addr = i_ext[AW-1:0];
         plpad_pkg::ADDR_I1:   rd_addr = i_p1[AW-1:0];
         plpad_pkg::ADDR_I2:   rd_addr = i_p2[AW-1:0];
         plpad_pkg::ADDR_LAST: rd_addr = last_idx[AW-1:0];
         default:              rd_addr = i_ext[AW-1:0];
      endcase
   end

   plpad_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_point_z, req_point_y, req_point_x}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- per-axis operands ----------------
   always_comb begin
      case (ctrl.axis)
         2'd1: begin
            va = pa_ff[2*W-1:W];
            vb = pb_ff[2*W-1:W];
         end
         2'd2: begin
            va = pa_ff[3*W-1:2*W];
            vb = pb_ff[3*W-1:2*W];
         end
         default: begin
            va = pa_ff[W-1:0];
            vb = pb_ff[W-1:0];
         end
      endcase
      diff  = {vb[W-1], vb} - {va[W-1], va};
      mag   = diff[W] ? plpad_pkg::MAG_W'(-diff) : plpad_pkg::MAG_W'(diff);
      mul_b = ctrl.mul_sq ? mag : plpad_pkg::MAG_W'(ratio_ff);
   end

   // ---------------- sqrt / divide steps ----------------
   assign s_shift = {srem_ff[plpad_pkg::SREM_W-3:0],
                     rad_ff[plpad_pkg::RAD_W-1:plpad_pkg::RAD_W-2]};
   assign s_trial = plpad_pkg::SREM_W'({root_ff, 2'b01});
   assign len_ext = plpad_pkg::DREM_W'(root_ff);
   assign d_shift = {drem_ff[plpad_pkg::DREM_W-2:0], 1'b0};

   // offset rounds half up on the magnitude
   assign rounded = prod_ff + plpad_pkg::PROD_W'(1 << (plpad_pkg::RATIO_BITS - 1));
   assign offset  = rounded[plpad_pkg::RATIO_BITS+plpad_pkg::MAG_W-1:plpad_pkg::RATIO_BITS];
   assign interp  = diff[W] ? ({va[W-1], va} - offset) : ({va[W-1], va} + offset);

   // ---------------- status ----------------
   assign stat.count_zero  = (count_ff == '0);
   assign stat.past_end    = !(i_p1 < count_ext);
   assign stat.rem_lt_len  = $signed({{4{remain_ff[W-1]}}, remain_ff}) < $signed({1'b0, root_ff});
   assign stat.rem_le_zero = remain_ff[W-1] || (remain_ff == '0);
   assign stat.more_seg    = i_p2 < count_ext;
   assign stat.out_busy    = out_valid_ff && !rsp_ready;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctrl.pub) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.q_start) begin
         i_ff      <= IW'(req_start_index);
         remain_ff <= req_travel_distance;
      end
      if (ctrl.lat_a) begin
         pa_ff <= rd_data;
      end
      if (ctrl.lat_b) begin
         pb_ff  <= rd_data;
         acc_ff <= '0;
      end
      if (ctrl.mul_sq || ctrl.mul_int) begin
         prod_ff <= plpad_pkg::PROD_W'(mag) * plpad_pkg::PROD_W'(mul_b);
      end
      if (ctrl.acc_add) begin
         acc_ff <= acc_ff + plpad_pkg::ACC_W'(prod_ff);
      end
      if (ctrl.sqrt_init) begin
         rad_ff  <= plpad_pkg::RAD_W'(acc_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (ctrl.sqrt_step) begin
         rad_ff <= {rad_ff[plpad_pkg::RAD_W-3:0], 2'b00};
         if (s_shift >= s_trial) begin
            srem_ff <= s_shift - s_trial;
            root_ff <= {root_ff[plpad_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= s_shift;
            root_ff <= {root_ff[plpad_pkg::ROOT_W-2:0], 1'b0};
         end
      end
      if (ctrl.advance) begin
         pa_ff     <= pb_ff;
         i_ff      <= i_ff + 1'b1;
         remain_ff <= remain_ff - W'(root_ff);
      end
      if (ctrl.advance && !ctrl.set_tail) begin
         pb_ff  <= rd_data;
         acc_ff <= '0;
      end
      if (ctrl.div_init) begin
         drem_ff    <= plpad_pkg::DREM_W'(remain_ff);
         ratio_ff   <= '0;
         res_idx_ff <= i_ff[plpad_pkg::IDX_W-1:0];
         res_err_ff <= 1'b0;
      end
      if (ctrl.div_step) begin
         if (d_shift >= len_ext) begin
            drem_ff  <= d_shift - len_ext;
            ratio_ff <= {ratio_ff[plpad_pkg::RATIO_BITS-2:0], 1'b1};
         end else begin
            drem_ff  <= d_shift;
            ratio_ff <= {ratio_ff[plpad_pkg::RATIO_BITS-2:0], 1'b0};
         end
      end
      if (ctrl.int_apply) begin
         case (ctrl.axis)
            2'd1:    res_y_ff <= interp[W-1:0];
            2'd2:    res_z_ff <= interp[W-1:0];
            default: res_x_ff <= interp[W-1:0];
         endcase
      end
      if (ctrl.set_empty) begin
         res_x_ff   <= '0;
         res_y_ff   <= '0;
         res_z_ff   <= '0;
         res_idx_ff <= '0;
         res_err_ff <= 1'b1;
      end
      if (ctrl.set_last) begin
         {res_z_ff, res_y_ff, res_x_ff} <= rd_data;
         res_idx_ff <= last_idx[plpad_pkg::IDX_W-1:0];
         res_err_ff <= 1'b0;
      end
      if (ctrl.set_start) begin
         {res_z_ff, res_y_ff, res_x_ff} <= pa_ff;
         res_idx_ff <= i_ff[plpad_pkg::IDX_W-1:0];
         res_err_ff <= 1'b0;
      end
      if (ctrl.set_tail) begin
         {res_z_ff, res_y_ff, res_x_ff} <= pb_ff;
         res_idx_ff <= i_p1[plpad_pkg::IDX_W-1:0];
         res_err_ff <= 1'b0;
      end
      if (ctrl.pub) begin
         out_x_ff   <= res_x_ff;
         out_y_ff   <= res_y_ff;
         out_z_ff   <= res_z_ff;
         out_idx_ff <= res_idx_ff;
         out_err_ff <= res_err_ff;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_result_x          = out_x_ff;
   assign rsp_result_y          = out_y_ff;
   assign rsp_result_z          = out_z_ff;
   assign rsp_orientation_index = out_idx_ff;
   assign rsp_empty_error       = out_err_ff;

endmodule

// ===== rtl/core/polyline_point_at_arc_distance.sv =====
// ----------------------------------------------------------------------------
// polyline_point_at_arc_distance
// Point on a stored 3D polyline at a given arc distance from a start index.
// ----------------------------------------------------------------------------
// A load is accepted whenever the block is idle, also while a result waits on the
// response port. A query walks its segments in turn, each through the 35-step
// bit-serial square root of the segment length; when it ends inside a segment it
// then runs the 28-step ratio divider and the three interpolation multiplies.
// Points are held in one RAM read one entry per cycle; the block works one query
// at a time.
module polyline_point_at_arc_distance #(
   parameter int MAX_POINTS = 1024
) (
   input logic         clock,
   input logic         reset,
   plpad_req_if.sink   req_chan,
   plpad_rsp_if.source rsp_chan
);

   plpad_pkg::ctrl_type ctrl;
   plpad_pkg::stat_type stat;

   plpad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   plpad_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .ctrl                  (ctrl),
      .stat                  (stat),
      .req_first_point       (req_chan.first_point),
      .req_point_x           (req_chan.point_x),
      .req_point_y           (req_chan.point_y),
      .req_point_z           (req_chan.point_z),
      .req_start_index       (req_chan.start_index),
      .req_travel_distance   (req_chan.travel_distance),
      .rsp_ready             (rsp_chan.ready),
      .rsp_valid             (rsp_chan.valid),
      .rsp_result_x          (rsp_chan.result_x),
      .rsp_result_y          (rsp_chan.result_y),
      .rsp_result_z          (rsp_chan.result_z),
      .rsp_orientation_index (rsp_chan.orientation_index),
      .rsp_empty_error       (rsp_chan.empty_error)
   );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for polyline_point_at_arc_distance: loads short polylines
// and a full store, runs distance queries and compares every found point with
// a local fixed-point predictor, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

   localparam int STORE_DEPTH = 1024;
   localparam int ITEM_TARGET = 1400;

   typedef struct packed {
      logic               cmd;
      logic               first_point;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [9:0]         start_index;
      logic signed [31:0] travel_distance;
   } req_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [9:0]  orient;
      logic        empty;
   } found_type;

   logic clock;
   logic reset;

   plpad_req_if req();
   plpad_rsp_if rsp();

   polyline_point_at_arc_distance dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req.sink),
      .rsp_chan(rsp.source)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // predictor state
   logic [31:0] pts_x [STORE_DEPTH];
   logic [31:0] pts_y [STORE_DEPTH];
   logic [31:0] pts_z [STORE_DEPTH];
   int          pts_count;

   found_type found_q[$];
   bit        failed;
   int        items_sent;
   int        steady_left;
   int        stall_left;

   function automatic logic [32:0] abs_span(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'($signed(b)) - longint'($signed(a));
      return (d < 0) ? 33'(-d) : 33'(d);
   endfunction

   function automatic logic [34:0] seg_length(int i);
      logic [69:0] sum_sq;
      logic [69:0] cand_sq;
      logic [32:0] d;
      logic [34:0] root;
      logic [34:0] cand;
      sum_sq = '0;
      d = abs_span(pts_x[i], pts_x[i+1]);
      sum_sq += 70'(d) * 70'(d);
      d = abs_span(pts_y[i], pts_y[i+1]);
      sum_sq += 70'(d) * 70'(d);
      d = abs_span(pts_z[i], pts_z[i+1]);
      sum_sq += 70'(d) * 70'(d);
      root = '0;
      for (int b = plpad_pkg::ROOT_W - 1; b >= 0; b--) begin
         cand = root | (35'd1 << b);
         cand_sq = 70'(cand) * 70'(cand);
         if (cand_sq <= sum_sq) root = cand;
      end
      return root;
   endfunction

   function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                        longint unsigned ratio);
      longint          va;
      longint          vb;
      longint unsigned mag;
      longint unsigned off;
      va = longint'($signed(a));
      vb = longint'($signed(b));
      mag = 64'(abs_span(a, b));
      off = (mag * ratio + (64'd1 << (plpad_pkg::RATIO_BITS - 1))) >> plpad_pkg::RATIO_BITS;
      return (vb < va) ? 32'(va - longint'(off)) : 32'(va + longint'(off));
   endfunction

   function automatic found_type stored_point(int i);
      found_type f;
      f.x = pts_x[i];
      f.y = pts_y[i];
      f.z = pts_z[i];
      f.orient = 10'(i);
      f.empty = 1'b0;
      return f;
   endfunction

   function automatic found_type point_at_distance(logic [9:0] start, logic [31:0] travel);
      found_type       f;
      longint          remain;
      longint unsigned len;
      longint unsigned ratio;
      if (pts_count == 0) begin
         f = '0;
         f.empty = 1'b1;
         return f;
      end
      remain = longint'($signed(travel));
      for (int i = int'(start); i + 1 < pts_count; i++) begin
         len = 64'(seg_length(i));
         if (remain < longint'(len)) begin
            if (remain <= 0) return stored_point(i);
            ratio = (64'(remain) << plpad_pkg::RATIO_BITS) / len;
            f.x = lerp(pts_x[i], pts_x[i+1], ratio);
            f.y = lerp(pts_y[i], pts_y[i+1], ratio);
            f.z = lerp(pts_z[i], pts_z[i+1], ratio);
            f.orient = 10'(i);
            f.empty = 1'b0;
            return f;
         end
         remain -= longint'(len);
      end
      return stored_point(pts_count - 1);
   endfunction

   function automatic void apply_item(req_type r);
      if (r.cmd == plpad_pkg::CMD_LOAD) begin
         if (r.first_point) pts_count = 0;
         if (pts_count < STORE_DEPTH) begin
            pts_x[pts_count] = r.point_x;
            pts_y[pts_count] = r.point_y;
            pts_z[pts_count] = r.point_z;
            pts_count++;
         end
      end else begin
         found_q.push_back(point_at_distance(r.start_index, r.travel_distance));
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(req_type r);
      int gap;
      if (steady_left > 0) begin
         gap = 0;
         steady_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 39) == 0) steady_left = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid           <= 1'b1;
      req.cmd             <= r.cmd;
      req.first_point     <= r.first_point;
      req.point_x         <= r.point_x;
      req.point_y         <= r.point_y;
      req.point_z         <= r.point_z;
      req.start_index     <= r.start_index;
      req.travel_distance <= r.travel_distance;
      do @(posedge clock); while (!req.ready);
      apply_item(r);
      items_sent++;
   endtask

   task automatic load_point(bit first, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      req_type r;
      r.cmd = plpad_pkg::CMD_LOAD;
      r.first_point = first;
      r.point_x = x;
      r.point_y = y;
      r.point_z = z;
      // query fields carry junk, the block must ignore them
      r.start_index = 10'($urandom);
      r.travel_distance = $urandom;
      send_item(r);
   endtask

   task automatic query(logic [9:0] start, logic [31:0] travel);
      req_type r;
      r.cmd = plpad_pkg::CMD_QUERY;
      r.first_point = 1'($urandom);
      r.point_x = $urandom;
      r.point_y = $urandom;
      r.point_z = $urandom;
      r.start_index = start;
      r.travel_distance = travel;
      send_item(r);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (found_q.size() != 0) @(posedge clock);
   endtask

   // result side: random backpressure and field checks
   always @(posedge clock) begin
      found_type exp_f;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (found_q.size() == 0) begin
               $error("result item with nothing expected");
               failed = 1'b1;
            end else begin
               exp_f = found_q.pop_front();
               if (rsp.result_x !== exp_f.x) begin
                  $error("result_x expected %h got %h", exp_f.x, rsp.result_x);
                  failed = 1'b1;
               end
               if (rsp.result_y !== exp_f.y) begin
                  $error("result_y expected %h got %h", exp_f.y, rsp.result_y);
                  failed = 1'b1;
               end
               if (rsp.result_z !== exp_f.z) begin
                  $error("result_z expected %h got %h", exp_f.z, rsp.result_z);
                  failed = 1'b1;
               end
               if (rsp.orientation_index !== exp_f.orient) begin
                  $error("orientation_index expected %0d got %0d", exp_f.orient,
                         rsp.orientation_index);
                  failed = 1'b1;
               end
               if (rsp.empty_error !== exp_f.empty) begin
                  $error("empty_error expected %b got %b", exp_f.empty, rsp.empty_error);
                  failed = 1'b1;
               end
            end
         end
         if (stall_left > 0) begin
            rsp.ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            rsp.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
         end
      end
   end

   task automatic test_directed();
      // query before any load hits the empty store
      query(10'd0, 32'd100);
      query(10'h3FF, 32'h7FFF_FFFF);
      // single point store
      load_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      query(10'd0, 32'd5000);
      // segment spanning the full range in x and y
      load_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      query(10'd0, 32'd0);
      query(10'd0, 32'hFFFF_FFFF);
      query(10'd0, 32'h8000_0000);
      query(10'd0, 32'h7FFF_FFFF);
      query(10'd0, 32'd1);
      query(10'd1, 32'd1000);
      query(10'h3FF, 32'd1000);
      // zero length segment between two short ones
      load_point(1'b1, 32'd0, 32'd0, 32'd0);
      load_point(1'b0, 32'd3072, 32'd4096, 32'd0);
      load_point(1'b0, 32'd3072, 32'd4096, 32'd0);
      load_point(1'b0, 32'd3072, 32'd4096, 32'hFFFF_F000);
      query(10'd0, 32'd5120);
      query(10'd0, 32'd2560);
      query(10'd0, 32'd7000);
      query(10'd1, 32'd0);
      query(10'd0, 32'd20000);
      query(10'd2, 32'hFFFF_FF00);
      drain();
   endtask

   task automatic test_full_store();
      logic [31:0] x;
      x = $urandom;
      for (int i = 0; i < STORE_DEPTH; i++)
         load_point(i == 0, x + 32'(i * 1024), 32'(i * 512), $urandom_range(0, 2048));
      // store is full: this load must be dropped
      load_point(1'b0, $urandom, $urandom, $urandom);
      query(10'h3FF, 32'd100);
      query(10'd1022, 32'h7FFF_FFFF);
      query(10'd1015, 32'd4000);
      query(10'd1000, $urandom_range(0, 20000));
      // one long walk over every segment
      query(10'd0, 32'h7FFF_FFFF);
      drain();
   endtask

   function automatic logic [31:0] pick_coord(int spread, logic [31:0] base);
      case (spread)
         0: return base + 32'($signed($urandom_range(0, 8191)) - 4096);
         1: return base + 32'($signed($urandom_range(0, 2097151)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_paths();
      int              n;
      int              spread;
      int              pick;
      longint unsigned total;
      longint unsigned cut;
      logic [31:0]     bx;
      logic [31:0]     by;
      logic [31:0]     bz;
      logic [31:0]     dist_val;
      logic [9:0]      start;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: stray loads and queries from anywhere
            if ($urandom_range(0, 1)) load_point(1'($urandom), $urandom, $urandom, $urandom);
            else query(10'($urandom), $urandom);
            continue;
         end
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
         spread = $urandom_range(0, 2);
         bx = $urandom;
         by = $urandom;
         bz = $urandom;
         for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 11) == 0) begin
               load_point(1'b0, pts_x[pts_count-1], pts_y[pts_count-1], pts_z[pts_count-1]);
            end else begin
               bx = pick_coord(spread, bx);
               by = pick_coord(spread, by);
               bz = pick_coord(spread, bz);
               load_point(i == 0, bx, by, bz);
            end
         end
         total = 0;
         for (int i = 0; i + 1 < pts_count; i++) total += 64'(seg_length(i));
         repeat ($urandom_range(1, 4)) begin
            start = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, n + 2)) : 10'd0;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               cut = total + total / 8 + 1;
               cut = (64'($urandom) << 16 ^ 64'($urandom)) % cut;
               dist_val = (cut > 64'h7FFF_FFFF) ? $urandom : 32'(cut);
            end else if (pick < 7) begin
               // land exactly on a vertex when the walk starts at index 0
               cut = 0;
               for (int i = 0; i < $urandom_range(0, n) && i + 1 < pts_count; i++)
                  cut += 64'(seg_length(i));
               dist_val = (cut > 64'h7FFF_FFFF) ? 32'd0 : 32'(cut);
            end else if (pick < 8) begin
               dist_val = -32'($urandom_range(0, 100000));
            end else begin
               dist_val = $urandom;
            end
            query(start, dist_val);
         end
      end
      drain();
   endtask

   initial begin
      failed = 1'b0;
      items_sent = 0;
      steady_left = 0;
      pts_count = 0;
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.cmd <= plpad_pkg::CMD_LOAD;
      req.first_point <= 1'b0;
      req.point_x <= '0;
      req.point_y <= '0;
      req.point_z <= '0;
      req.start_index <= '0;
      req.travel_distance <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random_paths();
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/plpad_pkg.sv
rtl/core/plpad_req_if.sv
rtl/core/plpad_rsp_if.sv
rtl/core/plpad_ram.sv
rtl/core/plpad_ctrl.sv
rtl/core/plpad_dp.sv
rtl/core/polyline_point_at_arc_distance.sv
tb/tb.sv
